// ----- design/csm_pkg.sv -----
// ---------------------------------------------------------------------------
// csm_pkg: shared types and constants for the CSR sparse matrix-vector block
// Action codes, stage and result records, fixed field widths and defaults.
// ---------------------------------------------------------------------------
package csm_pkg;

   // fixed field widths
   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 32;
   localparam int ROW_IDX_W  = 16;
   localparam int SUM_W      = 48;
   localparam int COLS_W     = 11;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int FRAC_BITS  = 16;

   // parameter defaults
   localparam int          CSM_MAX_COLUMNS     = 1024;
   localparam longint      CSM_ROW_INDEX_LIMIT = 64'd65536;

   // columns_in_use after reset
   localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;

   // largest store depth the index field can address
   localparam int INDEX_SPAN = 1 << INDEX_W;

   // result queue depth: covers the round trip from row end to pop
   localparam int QDEPTH  = 8;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 2'd0,
      ACT_NZ   = 2'd1,
      ACT_EOR  = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   // item after the input register
   typedef struct packed {
      logic                      valid;
      action_type                kind;
      logic                      add;    // in-range nonzero
      logic                      err;    // out-of-range nonzero
      logic signed [VALUE_W-1:0] value;
   } stage_type;

   // finished row headed for the result queue
   typedef struct packed {
      logic                     valid;
      logic [ROW_IDX_W-1:0]     row_index;
      logic signed [SUM_W-1:0]  row_sum;
      logic                     index_error;
   } result_type;

endpackage

// ----- design/csm_req_if.sv -----
// ---------------------------------------------------------------------------
// csm_req_if: input channel
// Valid/ready channel carrying one matrix stream item per beat.
// ---------------------------------------------------------------------------
interface csm_req_if
   import csm_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic [INDEX_W-1:0]        index;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

// ----- design/csm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// csm_rsp_if: result channel
// Valid/ready channel carrying one finished row per beat.
// ---------------------------------------------------------------------------
interface csm_rsp_if
   import csm_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [ROW_IDX_W-1:0]     row_index;
   logic signed [SUM_W-1:0]  row_sum;
   logic                     index_error;

   modport source (output valid, output row_index, output row_sum, output index_error,
                   input ready);
   modport sink   (input valid, input row_index, input row_sum, input index_error,
                   output ready);
endinterface

// ----- design/csm_vec_store.sv -----
// ---------------------------------------------------------------------------
// csm_vec_store: dense vector memory
// One write port for element loads, one registered read port.
// ---------------------------------------------------------------------------
module csm_vec_store
   import csm_pkg::*;
#(
   parameter int DEPTH = CSM_MAX_COLUMNS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // write on load, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/csm_mac.sv -----
// ---------------------------------------------------------------------------
// csm_mac: multiply and accumulate stages
// Registers the floored Q32.16 product, then adds it into the saturating
// row accumulator and emits the row result on end of row.
// ---------------------------------------------------------------------------
module csm_mac
   import csm_pkg::*;
#(
   parameter longint ROW_INDEX_LIMIT = CSM_ROW_INDEX_LIMIT,
   parameter int     ROW_W = (ROW_INDEX_LIMIT > 2) ? $clog2(ROW_INDEX_LIMIT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  stage_type          s1,
   input  logic [VALUE_W-1:0] vec_data,
   output result_type         push
);

   logic signed [PROD_W-1:0] prod_full;
   logic signed [PROD_W-1:0] prod_shift;

   logic                     s2_valid_ff;
   action_type               s2_kind_ff;
   logic                     s2_add_ff;
   logic                     s2_err_ff;
   logic signed [SUM_W-1:0]  s2_prod_ff;

   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic                     sticky_ff, sticky_in;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   result_type               push_in, push_ff;

   // exact product, floor shift to Q32.16
   always_comb begin
      prod_full  = PROD_W'(s1.value) * PROD_W'(signed'(vec_data));
      prod_shift = prod_full >>> FRAC_BITS;
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1.valid;
      end
      s2_kind_ff <= s1.kind;
      s2_add_ff  <= s1.add;
      s2_err_ff  <= s1.err;
      s2_prod_ff <= prod_shift[SUM_W-1:0];
   end

   // saturating add
   always_comb begin
      sum_wide = {acc_ff[SUM_W-1], acc_ff} + {s2_prod_ff[SUM_W-1], s2_prod_ff};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // accumulate, flag and close rows
   always_comb begin
      acc_in    = acc_ff;
      row_in    = row_ff;
      sticky_in = sticky_ff;
      push_in   = '0;
      if (s2_valid_ff) begin
         unique case (s2_kind_ff)
            ACT_NZ: begin
               if (s2_add_ff) begin
                  acc_in = sum_sat;
               end
               if (s2_err_ff) begin
                  sticky_in = 1'b1;
               end
            end
            ACT_EOR: begin
               push_in.valid       = 1'b1;
               push_in.row_index   = ROW_IDX_W'(row_ff);
               push_in.row_sum     = acc_ff;
               push_in.index_error = sticky_ff;
               acc_in              = '0;
               row_in = (row_ff == ROW_W'(ROW_INDEX_LIMIT - 1)) ? '0 : row_ff + 1'b1;
            end
            ACT_LOAD, ACT_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         row_ff        <= '0;
         sticky_ff     <= 1'b0;
         push_ff.valid <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         row_ff        <= row_in;
         sticky_ff     <= sticky_in;
         push_ff.valid <= push_in.valid;
      end
      push_ff.row_index   <= push_in.row_index;
      push_ff.row_sum     <= push_in.row_sum;
      push_ff.index_error <= push_in.index_error;
   end

   assign push = push_ff;

endmodule

// ----- design/csm_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// csm_rsp_fifo: result queue
// Small register queue that holds finished rows until the receiver takes
// them; drives the result channel from registers.
// ---------------------------------------------------------------------------
module csm_rsp_fifo
   import csm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  result_type    push,
   csm_rsp_if.source     rsp
);

   result_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  pop;

   assign pop = rsp.valid && rsp.ready;

   // store pushed rows
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push;
      end
   end

   // advance pointers and occupancy
   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign rsp.valid       = (count_ff != '0);
   assign rsp.row_index   = entry_ff[rd_ptr_ff].row_index;
   assign rsp.row_sum     = entry_ff[rd_ptr_ff].row_sum;
   assign rsp.index_error = entry_ff[rd_ptr_ff].index_error;

endmodule

// ----- design/csr_sparse_matvec.sv -----
// ---------------------------------------------------------------------------
// csr_sparse_matvec: CSR sparse matrix times dense vector, Q16.16
// Usage: load the dense vector over req with action LOAD (index, value),
// then stream nonzeros in row order with action NONZERO (column, value) and
// close each row with action END_OF_ROW. Each END_OF_ROW beat yields one rsp
// beat: row number, saturated Q32.16 row sum and the sticky column error.
// csr_wr_en/csr_wr_data set columns_in_use; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Throughput: one req beat per cycle while req_ready is high, including
// back-to-back row ends. Path: input register with vector read, product
// register, accumulate and result register, then the result queue.
// Reset: accumulator, row counter, error flag and queue clear, and
// columns_in_use returns to 1024; the vector store keeps no reset value.
// Stall: finished rows wait in an eight-entry queue; req_ready drops while
// eight row results are in flight or queued, and nonzeros and loads are
// accepted freely otherwise.
// ---------------------------------------------------------------------------
module csr_sparse_matvec
   import csm_pkg::*;
#(
   parameter int     MAX_COLUMNS     = CSM_MAX_COLUMNS,
   parameter longint ROW_INDEX_LIMIT = CSM_ROW_INDEX_LIMIT
) (
   input  logic               clock,
   input  logic               reset,
   csm_req_if.sink            req,
   csm_rsp_if.source          rsp,
   input  logic               csr_wr_en,
   input  logic [COLS_W-1:0]  csr_wr_data
);

   localparam int STORE_DEPTH = (MAX_COLUMNS < INDEX_SPAN) ? MAX_COLUMNS : INDEX_SPAN;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [COLS_W-1:0]  cols_ff;
   logic               accept;
   logic               in_range;
   action_type         req_kind;
   stage_type          s1_ff, s1_in;
   logic [VALUE_W-1:0] vec_data;
   result_type         push;
   logic [QCNT_W-1:0]  credit_ff, credit_in;
   logic               eor_in, rsp_pop;

   // column count register
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
      end else if (csr_wr_en) begin
         cols_ff <= csr_wr_data;
      end
   end

   // decode the beat
   assign accept   = req.valid && req.ready;
   assign req_kind = action_type'(req.action);
   assign in_range = (COLS_W'(req.index) < cols_ff) &&
                     (32'(req.index) < 32'(MAX_COLUMNS));

   always_comb begin
      s1_in.valid = accept;
      s1_in.kind  = req_kind;
      s1_in.add   = (req_kind == ACT_NZ) && in_range;
      s1_in.err   = (req_kind == ACT_NZ) && !in_range;
      s1_in.value = req.value;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.kind  <= s1_in.kind;
      s1_ff.add   <= s1_in.add;
      s1_ff.err   <= s1_in.err;
      s1_ff.value <= s1_in.value;
   end

   csm_vec_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && (req_kind == ACT_LOAD) && in_range),
      .wr_addr (req.index[AW-1:0]),
      .wr_data (req.value),
      .rd_addr (req.index[AW-1:0]),
      .rd_data (vec_data)
   );

   csm_mac #(
      .ROW_INDEX_LIMIT (ROW_INDEX_LIMIT)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .s1       (s1_ff),
      .vec_data (vec_data),
      .push     (push)
   );

   csm_rsp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .rsp   (rsp)
   );

   // count rows in flight plus rows queued
   assign eor_in  = accept && (req_kind == ACT_EOR);
   assign rsp_pop = rsp.valid && rsp.ready;

   always_comb begin
      credit_in = credit_ff;
      if (eor_in && !rsp_pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (!eor_in && rsp_pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req.ready = (credit_ff < QCNT_W'(QDEPTH));

   // checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= QCNT_W'(QDEPTH))
      else $error("row credit count beyond queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (credit_ff != '0))
      else $error("result shown with no row outstanding");

   a_eor_takes_credit: assert property (@(posedge clock) disable iff (reset)
      (eor_in && !rsp_pop) |=> (credit_ff == $past(credit_ff) + 1'b1))
      else $error("end of row did not claim a queue slot");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

endmodule

// ----- tb/sv/csr_sparse_matvec_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csr_sparse_matvec_tb: self-checking bench for the CSR sparse mat-vec block
// Walks a short table of directed beats, then random rows of nonzeros under
// several column counts and idle patterns. Every finished row coming back is
// scored against a cycle-free row-sum predictor kept alongside the block.
// ---------------------------------------------------------------------------
module csr_sparse_matvec_tb;
   import csm_pkg::*;

   localparam int     CLK_HALF      = 6;
   localparam int     RESET_CYCLES  = 8;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     STALL_LIMIT   = 2000;
   localparam int     MAX_REPORTS   = 10;
   localparam int     RAND_ITEMS    = 750;
   localparam int     STORE_DEPTH   = CSM_MAX_COLUMNS;
   localparam int     DIR_ROWS      = 29;
   localparam longint SUM_MAX       = (64'sd1 <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN       = -SUM_MAX - 1;

   typedef struct packed {
      logic [ROW_IDX_W-1:0]    row_index;
      logic signed [SUM_W-1:0] row_sum;
      logic                    index_error;
   } row_beat_type;

   typedef enum logic {STEP_BEAT, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type       kind;
      logic [COLS_W-1:0]   cols;
      action_type          action;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
      logic                typed;
      row_beat_type        want;
   } dir_step_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [COLS_W-1:0] csr_wr_data;

   csm_req_if req_ch ();
   csm_rsp_if rsp_ch ();

   csr_sparse_matvec i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: vector copy, running sum, row number, sticky flag
   logic signed [VALUE_W-1:0] vec_mem [STORE_DEPTH];
   bit                        vec_set [STORE_DEPTH];
   longint                    row_acc;
   logic [ROW_IDX_W-1:0]      row_count;   // 16 bits wrap at the row limit
   logic                      col_error;
   logic [COLS_W-1:0]         cols_setting;
   row_beat_type              expected_rows [$];

   int idle_pct    = 0;
   int stall_pct   = 0;
   int error_count = 0;

   // directed beats; rows with typed results override the predictor
   dir_step_type dir_steps [DIR_ROWS] = '{
      // empty row straight after reset
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1, '{16'd0, 48'h0, 1'b0}},
      // vector: one, most negative, minus one lsb, most positive
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd0,    32'h0001_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd1,    32'h8000_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd2,    32'hFFFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd1023, 32'h7FFF_FFFF, 1'b0, '0},
      // two times one
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd0,    32'h0002_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd1, 48'h0000_0002_0000, 1'b0}},
      // most negative squared twice clamps high
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1,    32'h8000_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1,    32'h8000_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd2, 48'h7FFF_FFFF_FFFF, 1'b0}},
      // most positive times most negative three times clamps low
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1,    32'h7FFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1,    32'h7FFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1,    32'h7FFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd3, 48'h8000_0000_0000, 1'b0}},
      // tiny negative product floors to minus one lsb
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd2,    32'h0000_0001, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd4, 48'hFFFF_FFFF_FFFF, 1'b0}},
      // top column, mixed signs
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1023, 32'hFFFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd1023, 32'h7FFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b0, '0},
      // unused action does nothing
      '{STEP_BEAT, 11'd0, ACT_NOP,  10'd1023, 32'hFFFF_FFFF, 1'b0, '0},
      // four columns: load past the end is dropped, nonzero past it flags
      '{STEP_CSR,  11'd4, ACT_NOP,  10'd0,    32'h0000_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd4,    32'h1234_5678, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd4,    32'h0001_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd0,    32'h0001_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd6, 48'h0000_0001_0000, 1'b1}},
      // zero columns: every load dropped, every nonzero flags
      '{STEP_CSR,  11'd0, ACT_NOP,  10'd0,    32'h0000_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_LOAD, 10'd0,    32'h7FFF_FFFF, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_NZ,   10'd0,    32'h0001_0000, 1'b0, '0},
      '{STEP_BEAT, 11'd0, ACT_EOR,  10'd0,    32'h0000_0000, 1'b1,
        '{16'd7, 48'h0, 1'b1}}
   };

   function automatic int active_cols();
      return (cols_setting > COLS_W'(STORE_DEPTH)) ? STORE_DEPTH : int'(cols_setting);
   endfunction

   // advance the row-sum model by one beat; returns 1 when a row closes
   function automatic bit predict_row(input action_type act,
                                      input logic [INDEX_W-1:0] idx,
                                      input logic signed [VALUE_W-1:0] val,
                                      output row_beat_type res);
      int     lim;
      longint prod;
      longint sum;
      bit     emit;
      lim  = active_cols();
      emit = 1'b0;
      res  = '0;
      case (act)
         ACT_LOAD: begin
            if (int'(idx) < lim) begin
               vec_mem[idx] = val;
               vec_set[idx] = 1'b1;
            end
         end
         ACT_NZ: begin
            if (int'(idx) >= lim) begin
               col_error = 1'b1;
            end else begin
               // exact Q32.32 product, floor down to Q32.16, clamp the sum
               prod = (longint'(val) * longint'(vec_mem[idx])) >>> FRAC_BITS;
               sum  = row_acc + prod;
               if (sum > SUM_MAX) sum = SUM_MAX;
               else if (sum < SUM_MIN) sum = SUM_MIN;
               row_acc = sum;
            end
         end
         ACT_EOR: begin
            res.row_index   = row_count;
            res.row_sum     = row_acc[SUM_W-1:0];
            res.index_error = col_error;
            row_acc         = 0;
            row_count       = row_count + 1'b1;
            emit            = 1'b1;
         end
         default: ;
      endcase
      return emit;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] corners [5];
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
      case ($urandom_range(3))
         0: return VALUE_W'($urandom_range(1 << 19)) - VALUE_W'(1 << 18);
         1: return corners[$urandom_range(4)];
         default: return $urandom;
      endcase
   endfunction

   // offer one beat, hold it until taken, then update the model
   task automatic send_beat(input action_type act, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
      row_beat_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.index  <= idx;
      req_ch.value  <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_row(act, idx, val, res)) expected_rows.push_back(res);
   endtask

   // drop valid and wait for every outstanding row
   task automatic drain_rows();
      req_ch.valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
   endtask

   // change the column count once the pipeline is empty
   task automatic write_cols(input logic [COLS_W-1:0] cols);
      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cols;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cols_setting = cols;
   endtask

   // random rows against a freshly loaded slice of the vector
   task automatic run_phase(input logic [COLS_W-1:0] cols, input int send_idle,
                            input int recv_stall, input int n_items);
      int                 lim;
      int                 done;
      bit                 drained;
      logic [INDEX_W-1:0] pos;
      logic [INDEX_W-1:0] live_cols [$];
      write_cols(cols);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      lim       = active_cols();
      live_cols = '{INDEX_W'(0), INDEX_W'(lim - 1)};
      repeat ($urandom_range(10, 2)) live_cols.push_back(INDEX_W'($urandom_range(lim - 1)));
      foreach (live_cols[k]) send_beat(ACT_LOAD, live_cols[k], pick_value());
      done    = live_cols.size();
      drained = 1'b0;
      while (done < n_items) begin
         repeat ($urandom_range(6)) begin
            case ($urandom_range(11))
               0: begin
                  send_beat(ACT_NOP, INDEX_W'($urandom), $urandom);
                  done++;
               end
               1: begin
                  if (lim < STORE_DEPTH)
                     send_beat(ACT_LOAD, INDEX_W'($urandom_range(STORE_DEPTH - 1, lim)),
                               pick_value());
                  else
                     send_beat(ACT_NOP, INDEX_W'($urandom), $urandom);
                  done++;
               end
               2: begin
                  if (lim < STORE_DEPTH)
                     send_beat(ACT_NZ, INDEX_W'($urandom_range(STORE_DEPTH - 1, lim)),
                               pick_value());
                  else
                     send_beat(ACT_NZ, live_cols[$urandom_range(live_cols.size() - 1)],
                               pick_value());
                  done++;
               end
               3: begin
                  pos = INDEX_W'($urandom_range(lim - 1));
                  send_beat(ACT_LOAD, pos, pick_value());
                  live_cols.push_back(pos);
                  done++;
               end
               default: begin
                  send_beat(ACT_NZ, live_cols[$urandom_range(live_cols.size() - 1)],
                            pick_value());
                  done++;
               end
            endcase
         end
         send_beat(ACT_EOR, INDEX_W'($urandom), $urandom);
         done++;
         // hold off the sender once until the result queue runs dry
         if (!drained && done >= n_items / 2) begin
            drain_rows();
            drained = 1'b1;
         end
      end
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // random backpressure on the result channel
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // score each result beat against the oldest expectation
   always @(posedge clock) begin
      row_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rows.size() == 0) begin
            flag_error($sformatf("unexpected row idx %h sum %h err %b",
                                 rsp_ch.row_index, rsp_ch.row_sum, rsp_ch.index_error));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_ch.row_index !== want.row_index || rsp_ch.row_sum !== want.row_sum ||
                rsp_ch.index_error !== want.index_error)
               flag_error($sformatf("expected idx %h sum %h err %b, got idx %h sum %h err %b",
                                    want.row_index, want.row_sum, want.index_error,
                                    rsp_ch.row_index, rsp_ch.row_sum, rsp_ch.index_error));
         end
      end
   end

   // end the run if no beat moves on either channel for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_NOP;
      req_ch.index  <= '0;
      req_ch.value  <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      reset         <= 1'b1;
      row_acc       = 0;
      row_count     = '0;
      col_error     = 1'b0;
      cols_setting  = COLS_RESET;
      foreach (vec_set[i]) vec_set[i] = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_steps[i]) begin
         if (dir_steps[i].kind == STEP_CSR) begin
            write_cols(dir_steps[i].cols);
         end else begin
            send_beat(dir_steps[i].action, dir_steps[i].index, dir_steps[i].value);
            if (dir_steps[i].typed) expected_rows[expected_rows.size() - 1] = dir_steps[i].want;
         end
      end

      // random rows: full width, single column, mid width, over-range setting
      run_phase(COLS_RESET, 0, 0, RAND_ITEMS / 4);
      run_phase(COLS_W'(1), 50, 0, RAND_ITEMS / 4);
      run_phase(COLS_W'($urandom_range(STORE_DEPTH - 1, 2)), 0, 50, RAND_ITEMS / 4);
      run_phase({COLS_W{1'b1}}, 29, 29, RAND_ITEMS / 4);

      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
